/* hw/rtl/pascal_subset_lexer_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the lexer token queue.
// ----------------------------------------------------------------------------
`ifndef PASCAL_SUBSET_LEXER_TOP_MACROS_SVH
`define PASCAL_SUBSET_LEXER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

/* hw/rtl/psl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl_pkg
// Types, codes and keyword tables shared by the lexer modules.
// ----------------------------------------------------------------------------
package psl_pkg;

	localparam int KEYWORD_COUNT = 9;
	localparam int KW_MAX_LEN    = 8;

	localparam int BYTE_W = 8;
	localparam int KIND_W = 5;
	localparam int ERR_W  = 2;
	localparam int LINE_W = 32;
	localparam int OFF_W  = 32;
	localparam int LEN_W  = 16;
	localparam int MODE_W = 3;
	localparam int CLS_W  = 4;
	localparam int CFG_W  = 8;

	localparam logic [CFG_W-1:0]  MAX_NAME_RST = 8'd32;
	localparam logic [LINE_W-1:0] LINE_MAX     = '1;
	localparam logic [OFF_W-1:0]  OFF_MAX      = '1;
	localparam logic [LEN_W-1:0]  LEN_MAX      = '1;

	// Token kinds
	localparam logic [KIND_W-1:0] KIND_END     = 5'd0;
	localparam logic [KIND_W-1:0] KIND_NEWLINE = 5'd1;
	localparam logic [KIND_W-1:0] KIND_LE      = 5'd2;
	localparam logic [KIND_W-1:0] KIND_GE      = 5'd3;
	localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd4;
	localparam logic [KIND_W-1:0] KIND_NE      = 5'd5;
	localparam logic [KIND_W-1:0] KIND_LT      = 5'd6;
	localparam logic [KIND_W-1:0] KIND_GT      = 5'd7;
	localparam logic [KIND_W-1:0] KIND_EQ      = 5'd8;
	localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd9;
	localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd10;
	localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd11;
	localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd12;
	localparam logic [KIND_W-1:0] KIND_STAR    = 5'd13;
	localparam logic [KIND_W-1:0] KIND_INT     = 5'd14;
	localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd15;
	localparam logic [KIND_W-1:0] KIND_KW0     = 5'd16;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 5'd25;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_BAD_INT  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_LONG     = 2'd2;
	localparam logic [ERR_W-1:0] ERR_UNKNOWN  = 2'd3;

	// Lexer modes
	localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LT    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_GT    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_COLON = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ZERO  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_INT   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_NAME  = 3'd6;

	// Byte classes
	localparam logic [CLS_W-1:0] CLS_END    = 4'd0;
	localparam logic [CLS_W-1:0] CLS_NL     = 4'd1;
	localparam logic [CLS_W-1:0] CLS_WS     = 4'd2;
	localparam logic [CLS_W-1:0] CLS_LT     = 4'd3;
	localparam logic [CLS_W-1:0] CLS_GT     = 4'd4;
	localparam logic [CLS_W-1:0] CLS_COLON  = 4'd5;
	localparam logic [CLS_W-1:0] CLS_EQ     = 4'd6;
	localparam logic [CLS_W-1:0] CLS_SEMI   = 4'd7;
	localparam logic [CLS_W-1:0] CLS_LPAREN = 4'd8;
	localparam logic [CLS_W-1:0] CLS_RPAREN = 4'd9;
	localparam logic [CLS_W-1:0] CLS_MINUS  = 4'd10;
	localparam logic [CLS_W-1:0] CLS_STAR   = 4'd11;
	localparam logic [CLS_W-1:0] CLS_ZERO   = 4'd12;
	localparam logic [CLS_W-1:0] CLS_DIGIT  = 4'd13;
	localparam logic [CLS_W-1:0] CLS_ALPHA  = 4'd14;
	localparam logic [CLS_W-1:0] CLS_OTHER  = 4'd15;

	// Queue sizes
	localparam int FQ_DEPTH = 2;
	localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
	localparam int TQ_DEPTH = 4;
	localparam int TQ_PTR_W = $clog2(TQ_DEPTH);
	localparam int TQ_CNT_W = $clog2(TQ_DEPTH + 1);

	// Keyword text, first character in the top byte, zero padded.
	localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KEYWORD_COUNT] = '{
		{"integer", 8'h00},
		{"begin", 24'h0},
		{"end", 40'h0},
		{"if", 48'h0},
		{"then", 32'h0},
		{"else", 32'h0},
		"function",
		{"read", 32'h0},
		{"write", 24'h0}
	};
	localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
		4'd7, 4'd5, 4'd3, 4'd2, 4'd4, 4'd4, 4'd8, 4'd4, 4'd5
	};

	typedef struct packed {
		logic [CLS_W-1:0]  cls;
		logic [BYTE_W-1:0] data;
	} byte_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ERR_W-1:0]  err;
		logic [LINE_W-1:0] line;
		logic [OFF_W-1:0]  offset;
		logic [LEN_W-1:0]  length;
		logic              last;
	} token_t;

	// Keywords whose character at position pos equals b.
	function automatic logic [KEYWORD_COUNT-1:0] kw_match(logic [LEN_W-1:0] pos,
			logic [BYTE_W-1:0] b);
		logic [KEYWORD_COUNT-1:0] m;
		m = '0;
		for (int k = 0; k < KEYWORD_COUNT; k++) begin
			if (pos < LEN_W'(KW_LEN[k]) &&
					KW_TEXT[k][(8*KW_MAX_LEN - 1 - 8*int'(pos[2:0])) -: 8] == b) begin
				m[k] = 1'b1;
			end
		end
		return m;
	endfunction

endpackage

/* hw/rtl/psl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl_front
// Accepts source bytes, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module psl_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic [psl_pkg::BYTE_W-1:0]          source_byte,
	output logic                                full,
	output logic                                item_valid,
	output psl_pkg::byte_item_t                 item,
	input  logic                                item_take
);

	psl_pkg::byte_item_t                 mem_q [psl_pkg::FQ_DEPTH];
	logic [psl_pkg::FQ_PTR_W-1:0]        wr_ptr_q;
	logic [psl_pkg::FQ_PTR_W-1:0]        rd_ptr_q;
	logic [psl_pkg::FQ_CNT_W-1:0]        cnt_q;
	logic                                wr_en;
	logic                                rd_en;

	function automatic logic [psl_pkg::CLS_W-1:0] classify(logic [psl_pkg::BYTE_W-1:0] b);
		logic [psl_pkg::CLS_W-1:0] c;
		unique case (b) inside
			8'h00:                               c = psl_pkg::CLS_END;
			8'h0A:                               c = psl_pkg::CLS_NL;
			8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C:   c = psl_pkg::CLS_WS;
			8'h3C:                               c = psl_pkg::CLS_LT;
			8'h3E:                               c = psl_pkg::CLS_GT;
			8'h3A:                               c = psl_pkg::CLS_COLON;
			8'h3D:                               c = psl_pkg::CLS_EQ;
			8'h3B:                               c = psl_pkg::CLS_SEMI;
			8'h28:                               c = psl_pkg::CLS_LPAREN;
			8'h29:                               c = psl_pkg::CLS_RPAREN;
			8'h2D:                               c = psl_pkg::CLS_MINUS;
			8'h2A:                               c = psl_pkg::CLS_STAR;
			8'h30:                               c = psl_pkg::CLS_ZERO;
			[8'h31:8'h39]:                       c = psl_pkg::CLS_DIGIT;
			[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F: c = psl_pkg::CLS_ALPHA;
			default:                             c = psl_pkg::CLS_OTHER;
		endcase
		return c;
	endfunction

	assign full       = (cnt_q == psl_pkg::FQ_CNT_W'(psl_pkg::FQ_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign wr_en      = push && !full;
	assign rd_en      = item_take && item_valid;
	assign item       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + psl_pkg::FQ_PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + psl_pkg::FQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + psl_pkg::FQ_CNT_W'(wr_en) - psl_pkg::FQ_CNT_W'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= '{cls: classify(source_byte), data: source_byte};
		end
	end

endmodule

/* hw/rtl/psl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl_back
// Token state machine: consumes classified bytes and writes up to two tokens
// per byte into the token queue.
// ----------------------------------------------------------------------------
module psl_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [psl_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                item_valid,
	input  psl_pkg::byte_item_t                 item,
	output logic                                item_take,
	input  logic                                tq_room,
	output logic [1:0]                          wr_n,
	output psl_pkg::token_t                     wr_tok0,
	output psl_pkg::token_t                     wr_tok1
);

	logic [psl_pkg::CFG_W-1:0]          maxlen_q;
	logic [psl_pkg::MODE_W-1:0]         mode_q, mode_d;
	logic [psl_pkg::LINE_W-1:0]         line_q, line_d;
	logic [psl_pkg::OFF_W-1:0]          off_q, off_d;
	logic [psl_pkg::OFF_W-1:0]          start_q, start_d;
	logic [psl_pkg::LEN_W-1:0]          plen_q, plen_d;
	logic [psl_pkg::KEYWORD_COUNT-1:0]  cand_q, cand_d;

	psl_pkg::token_t                    t0, t1;
	logic                               v0, v1;
	logic                               consumed;
	logic                               is_dig, is_name;
	logic [psl_pkg::LEN_W-1:0]          plen_inc;
	logic [psl_pkg::CLS_W-1:0]          cls;

	function automatic logic [psl_pkg::KIND_W-1:0] name_kind(
			logic [psl_pkg::KEYWORD_COUNT-1:0] cand, logic [psl_pkg::LEN_W-1:0] len);
		logic [psl_pkg::KIND_W-1:0] kind;
		kind = psl_pkg::KIND_IDENT;
		for (int k = 0; k < psl_pkg::KEYWORD_COUNT; k++) begin
			if (cand[k] && len == psl_pkg::LEN_W'(psl_pkg::KW_LEN[k])) begin
				kind = psl_pkg::KIND_KW0 + psl_pkg::KIND_W'(k);
			end
		end
		return kind;
	endfunction

	assign item_take = item_valid && tq_room;
	assign cls       = item.cls;
	assign is_dig    = (cls == psl_pkg::CLS_ZERO) || (cls == psl_pkg::CLS_DIGIT);
	assign is_name   = is_dig || (cls == psl_pkg::CLS_ALPHA);
	assign plen_inc  = (plen_q == psl_pkg::LEN_MAX) ? plen_q : plen_q + psl_pkg::LEN_W'(1);

	always_comb begin
		mode_d   = mode_q;
		line_d   = line_q;
		off_d    = (off_q == psl_pkg::OFF_MAX) ? off_q : off_q + psl_pkg::OFF_W'(1);
		start_d  = start_q;
		plen_d   = plen_q;
		cand_d   = cand_q;
		consumed = 1'b0;
		v0       = 1'b0;
		v1       = 1'b0;
		t0       = '{kind: psl_pkg::KIND_END, err: psl_pkg::ERR_NONE, line: line_q,
			offset: start_q, length: psl_pkg::LEN_W'(1), last: 1'b0};
		t1       = '{kind: psl_pkg::KIND_END, err: psl_pkg::ERR_NONE, line: line_q,
			offset: off_q, length: psl_pkg::LEN_W'(1), last: 1'b1};

		// First the held token is either extended by this byte or closed.
		if (mode_q != psl_pkg::MODE_IDLE) begin
			mode_d = psl_pkg::MODE_IDLE;
		end
		unique case (mode_q)
			psl_pkg::MODE_IDLE: begin
			end
			psl_pkg::MODE_LT: begin
				v0 = 1'b1;
				if (cls == psl_pkg::CLS_EQ) begin
					t0.kind = psl_pkg::KIND_LE;
					t0.length = psl_pkg::LEN_W'(2);
					consumed = 1'b1;
				end else if (cls == psl_pkg::CLS_GT) begin
					t0.kind = psl_pkg::KIND_NE;
					t0.length = psl_pkg::LEN_W'(2);
					consumed = 1'b1;
				end else begin
					t0.kind = psl_pkg::KIND_LT;
				end
			end
			psl_pkg::MODE_GT: begin
				v0 = 1'b1;
				if (cls == psl_pkg::CLS_EQ) begin
					t0.kind = psl_pkg::KIND_GE;
					t0.length = psl_pkg::LEN_W'(2);
					consumed = 1'b1;
				end else begin
					t0.kind = psl_pkg::KIND_GT;
				end
			end
			psl_pkg::MODE_COLON: begin
				v0 = 1'b1;
				if (cls == psl_pkg::CLS_EQ) begin
					t0.kind = psl_pkg::KIND_ASSIGN;
					t0.length = psl_pkg::LEN_W'(2);
					consumed = 1'b1;
				end else begin
					t0.kind = psl_pkg::KIND_ERROR;
					t0.err  = psl_pkg::ERR_UNKNOWN;
				end
			end
			psl_pkg::MODE_ZERO: begin
				v0 = 1'b1;
				if (is_name) begin
					t0.kind = psl_pkg::KIND_ERROR;
					t0.err  = psl_pkg::ERR_BAD_INT;
				end else begin
					t0.kind = psl_pkg::KIND_INT;
				end
			end
			psl_pkg::MODE_INT: begin
				if (is_dig) begin
					plen_d   = plen_inc;
					mode_d   = psl_pkg::MODE_INT;
					consumed = 1'b1;
				end else begin
					v0 = 1'b1;
					t0.kind = psl_pkg::KIND_INT;
					t0.length = plen_q;
				end
			end
			psl_pkg::MODE_NAME: begin
				if (is_name) begin
					cand_d   = cand_q & psl_pkg::kw_match(plen_q, item.data);
					plen_d   = plen_inc;
					mode_d   = psl_pkg::MODE_NAME;
					consumed = 1'b1;
				end else begin
					v0 = 1'b1;
					t0.length = plen_q;
					if (plen_q > psl_pkg::LEN_W'(maxlen_q)) begin
						t0.kind = psl_pkg::KIND_ERROR;
						t0.err  = psl_pkg::ERR_LONG;
					end else begin
						t0.kind = name_kind(cand_q, plen_q);
					end
				end
			end
			default: begin
			end
		endcase

		// A byte that did not extend the held token is lexed from idle.
		if (!consumed) begin
			unique case (cls) inside
				psl_pkg::CLS_END: begin
					v1        = 1'b1;
					t1.kind   = psl_pkg::KIND_END;
					t1.length = '0;
					line_d    = psl_pkg::LINE_W'(1);
					off_d     = '0;
					start_d   = '0;
					plen_d    = '0;
					cand_d    = '1;
					mode_d    = psl_pkg::MODE_IDLE;
				end
				psl_pkg::CLS_NL: begin
					v1      = 1'b1;
					t1.kind = psl_pkg::KIND_NEWLINE;
					line_d  = (line_q == psl_pkg::LINE_MAX) ? line_q
						: line_q + psl_pkg::LINE_W'(1);
				end
				psl_pkg::CLS_WS: begin
				end
				psl_pkg::CLS_LT, psl_pkg::CLS_GT, psl_pkg::CLS_COLON,
				psl_pkg::CLS_ZERO, psl_pkg::CLS_DIGIT, psl_pkg::CLS_ALPHA: begin
					start_d = off_q;
					plen_d  = psl_pkg::LEN_W'(1);
					unique case (cls)
						psl_pkg::CLS_LT:    mode_d = psl_pkg::MODE_LT;
						psl_pkg::CLS_GT:    mode_d = psl_pkg::MODE_GT;
						psl_pkg::CLS_COLON: mode_d = psl_pkg::MODE_COLON;
						psl_pkg::CLS_ZERO:  mode_d = psl_pkg::MODE_ZERO;
						psl_pkg::CLS_DIGIT: mode_d = psl_pkg::MODE_INT;
						default: begin
							mode_d = psl_pkg::MODE_NAME;
							cand_d = psl_pkg::kw_match('0, item.data);
						end
					endcase
				end
				psl_pkg::CLS_EQ: begin
					v1 = 1'b1;
					t1.kind = psl_pkg::KIND_EQ;
				end
				psl_pkg::CLS_SEMI: begin
					v1 = 1'b1;
					t1.kind = psl_pkg::KIND_SEMI;
				end
				psl_pkg::CLS_LPAREN: begin
					v1 = 1'b1;
					t1.kind = psl_pkg::KIND_LPAREN;
				end
				psl_pkg::CLS_RPAREN: begin
					v1 = 1'b1;
					t1.kind = psl_pkg::KIND_RPAREN;
				end
				psl_pkg::CLS_MINUS: begin
					v1 = 1'b1;
					t1.kind = psl_pkg::KIND_MINUS;
				end
				psl_pkg::CLS_STAR: begin
					v1 = 1'b1;
					t1.kind = psl_pkg::KIND_STAR;
				end
				default: begin
					v1      = 1'b1;
					t1.kind = psl_pkg::KIND_ERROR;
					t1.err  = psl_pkg::ERR_UNKNOWN;
				end
			endcase
		end

		t0.last = !v1;
	end

	assign wr_n    = item_take ? (2'(v0) + 2'(v1)) : 2'd0;
	assign wr_tok0 = v0 ? t0 : t1;
	assign wr_tok1 = t1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxlen_q <= psl_pkg::MAX_NAME_RST;
			mode_q   <= psl_pkg::MODE_IDLE;
			line_q   <= psl_pkg::LINE_W'(1);
			off_q    <= '0;
			start_q  <= '0;
			plen_q   <= '0;
			cand_q   <= '1;
		end else begin
			if (cfg_we) begin
				maxlen_q <= cfg_wdata;
			end
			if (item_take) begin
				mode_q  <= mode_d;
				line_q  <= line_d;
				off_q   <= off_d;
				start_q <= start_d;
				plen_q  <= plen_d;
				cand_q  <= cand_d;
			end
		end
	end

endmodule

/* hw/rtl/psl_tokq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl_tokq
// Token queue: takes up to two tokens per cycle, hands out one per beat while not empty.
// ----------------------------------------------------------------------------
`include "pascal_subset_lexer_top_macros.svh"

module psl_tokq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          wr_n,
	input  psl_pkg::token_t                     wr_tok0,
	input  psl_pkg::token_t                     wr_tok1,
	output logic                                room,
	output logic                                empty,
	input  logic                                pop,
	output psl_pkg::token_t                     head
);

	psl_pkg::token_t                     mem_q [psl_pkg::TQ_DEPTH];
	logic [psl_pkg::TQ_PTR_W-1:0]        wr_ptr_q;
	logic [psl_pkg::TQ_PTR_W-1:0]        rd_ptr_q;
	logic [psl_pkg::TQ_CNT_W-1:0]        cnt_q;
	logic                                pop_ok;

	// Room means two free entries, so a byte that yields two tokens never stalls mid-way.
	assign room   = (cnt_q <= psl_pkg::TQ_CNT_W'(psl_pkg::TQ_DEPTH - 2));
	assign empty  = (cnt_q == '0);
	assign pop_ok = pop && !empty;
	assign head   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + psl_pkg::TQ_PTR_W'(wr_n);
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + psl_pkg::TQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + psl_pkg::TQ_CNT_W'(wr_n) - psl_pkg::TQ_CNT_W'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) begin
			mem_q[wr_ptr_q] <= wr_tok0;
		end
		if (wr_n == 2'd2) begin
			mem_q[wr_ptr_q + psl_pkg::TQ_PTR_W'(1)] <= wr_tok1;
		end
	end

	`ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= psl_pkg::TQ_CNT_W'(psl_pkg::TQ_DEPTH))
	`ASSERT_IMP(a_write_has_room, clk, arst_n, wr_n != 2'd0, room)
	`ASSERT_NXT(a_drain_last, clk, arst_n, pop_ok && wr_n == 2'd0 && cnt_q == psl_pkg::TQ_CNT_W'(1), empty)
	`ASSERT_NXT(a_fill_from_empty, clk, arst_n, empty && wr_n != 2'd0, !empty)

endmodule

/* hw/rtl/pascal_subset_lexer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pascal_subset_lexer_top
// Streaming lexer for a small Pascal subset, one source byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Source bytes enter on source_byte with push/full; a zero byte ends the
//   source, flushes any held token and emits an end mark.
//   Tokens leave as a queue: while empty is low the oldest token is on the
//   token_* ports, error_code and last_of_run; pop takes it.
//   cfg_we/cfg_wdata set the longest accepted name (reset value 32); write it
//   only while no bytes are in flight.
//   A token enters the token queue at the edge at which the state machine
//   takes the byte completing it; that byte first waits in the byte queue,
//   where it stays while the token queue has no room.
//   Throughput: one byte per cycle while the token queue has room, set by
//   the token state machine; a byte that yields two tokens needs two pops.
//   When pop stays low the four-entry token queue fills, the state machine
//   stops taking bytes, and full rises once the two-entry byte queue fills.
//   Reset empties both queues, sets the line to 1, the offset to 0 and the
//   name limit to 32.
// ----------------------------------------------------------------------------
module pascal_subset_lexer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic [psl_pkg::BYTE_W-1:0]          source_byte,
	output logic                                full,
	input  logic                                cfg_we,
	input  logic [psl_pkg::CFG_W-1:0]           cfg_wdata,
	output logic                                empty,
	input  logic                                pop,
	output logic [psl_pkg::KIND_W-1:0]          token_kind,
	output logic [psl_pkg::ERR_W-1:0]           error_code,
	output logic [psl_pkg::LINE_W-1:0]          token_line,
	output logic [psl_pkg::OFF_W-1:0]           token_offset,
	output logic [psl_pkg::LEN_W-1:0]           token_length,
	output logic                                last_of_run
);

	logic                  item_valid;
	psl_pkg::byte_item_t   item;
	logic                  item_take;
	logic                  tq_room;
	logic [1:0]            wr_n;
	psl_pkg::token_t       wr_tok0;
	psl_pkg::token_t       wr_tok1;
	psl_pkg::token_t       head;

	psl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.source_byte (source_byte),
		.full        (full),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take)
	);

	psl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.tq_room    (tq_room),
		.wr_n       (wr_n),
		.wr_tok0    (wr_tok0),
		.wr_tok1    (wr_tok1)
	);

	psl_tokq u_tokq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_n    (wr_n),
		.wr_tok0 (wr_tok0),
		.wr_tok1 (wr_tok1),
		.room    (tq_room),
		.empty   (empty),
		.pop     (pop),
		.head    (head)
	);

	assign token_kind   = head.kind;
	assign error_code   = head.err;
	assign token_line   = head.line;
	assign token_offset = head.offset;
	assign token_length = head.length;
	assign last_of_run  = head.last;

endmodule
